// ----- rtl/lnrast_pkg.sv -----
`default_nettype none

package lnrast_pkg;

    // Fixed field widths of the framebuffer side
    localparam int ROW_WIDTH_BITS  = 7;
    localparam int ADDR_BITS       = 12;
    localparam int ROW_WIDTH_RESET = 64;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;   // take a new segment from the input beat
        logic step;   // advance to the next pixel
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last;   // current pixel is the final one of the segment
    } t_status;

endpackage

`default_nettype wire

// ----- rtl/lnrast_dp.sv -----
`default_nettype none

module lnrast_dp #(
    parameter int COORD_BITS = 6
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  lnrast_pkg::t_cmd                          i_cmd,
    output lnrast_pkg::t_status                       o_status,
    input  wire                                       i_cfg_wr_en,
    input  wire  [lnrast_pkg::ROW_WIDTH_BITS-1:0]     i_cfg_wr_data,
    input  wire  [COORD_BITS-1:0]                     i_start_x,
    input  wire  [COORD_BITS-1:0]                     i_start_y,
    input  wire  [COORD_BITS-1:0]                     i_end_x,
    input  wire  [COORD_BITS-1:0]                     i_end_y,
    output logic [COORD_BITS-1:0]                     o_pixel_x,
    output logic [COORD_BITS-1:0]                     o_pixel_y,
    output logic [lnrast_pkg::ADDR_BITS-1:0]          o_pixel_address
);

    localparam int RWB = lnrast_pkg::ROW_WIDTH_BITS;
    localparam int AB  = lnrast_pkg::ADDR_BITS;
    localparam int PW  = COORD_BITS + RWB + 1;

    logic [RWB-1:0]        r_row_width;
    logic [COORD_BITS-1:0] r_x, r_y, r_err, r_steps, r_major, r_minor;
    logic                  r_major_is_x;
    logic                  r_x_inc, r_x_dec, r_y_inc, r_y_dec;
    logic [AB-1:0]         r_addr;

    logic [COORD_BITS-1:0] w_adx, w_ady;
    logic                  w_major_is_x;
    logic [PW-1:0]         w_load_addr;
    logic [COORD_BITS:0]   w_err_sum;
    logic                  w_minor_step, w_x_move, w_y_move;
    logic [COORD_BITS-1:0] n_x, n_y, n_err;
    logic [AB-1:0]         w_dx_addr, w_dy_addr, n_addr;

    // Setup of a new segment
    assign w_adx = (i_end_x >= i_start_x) ? (i_end_x - i_start_x) : (i_start_x - i_end_x);
    assign w_ady = (i_end_y >= i_start_y) ? (i_end_y - i_start_y) : (i_start_y - i_end_y);
    assign w_major_is_x = (w_adx >= w_ady);
    assign w_load_addr  = PW'(i_start_y) * PW'(r_row_width) + PW'(i_start_x);

    // One Bresenham step
    assign w_err_sum    = {1'b0, r_err} + {1'b0, r_minor};
    assign w_minor_step = (w_err_sum >= {1'b0, r_major});
    assign n_err        = w_minor_step ? COORD_BITS'(w_err_sum - {1'b0, r_major})
                                       : COORD_BITS'(w_err_sum);
    assign w_x_move     = r_major_is_x | w_minor_step;
    assign w_y_move     = ~r_major_is_x | w_minor_step;

    always_comb begin
        n_x       = r_x;
        n_y       = r_y;
        w_dx_addr = '0;
        w_dy_addr = '0;
        if (w_x_move) begin
            if (r_x_inc) begin
                n_x       = r_x + 1'b1;
                w_dx_addr = AB'(1);
            end else if (r_x_dec) begin
                n_x       = r_x - 1'b1;
                w_dx_addr = '1;
            end
        end
        if (w_y_move) begin
            if (r_y_inc) begin
                n_y       = r_y + 1'b1;
                w_dy_addr = AB'(r_row_width);
            end else if (r_y_dec) begin
                n_y       = r_y - 1'b1;
                w_dy_addr = AB'(0) - AB'(r_row_width);
            end
        end
        n_addr = r_addr + w_dx_addr + w_dy_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= RWB'(lnrast_pkg::ROW_WIDTH_RESET);
        end else if (i_cfg_wr_en) begin
            r_row_width <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x          <= '0;
            r_y          <= '0;
            r_err        <= '0;
            r_major_is_x <= 1'b0;
            r_major      <= '0;
            r_minor      <= '0;
            r_steps      <= '0;
            r_x_inc      <= 1'b0;
            r_x_dec      <= 1'b0;
            r_y_inc      <= 1'b0;
            r_y_dec      <= 1'b0;
            r_addr       <= '0;
        end else if (i_cmd.load) begin
            r_x          <= i_start_x;
            r_y          <= i_start_y;
            r_err        <= '0;
            r_major_is_x <= w_major_is_x;
            r_major      <= w_major_is_x ? w_adx : w_ady;
            r_minor      <= w_major_is_x ? w_ady : w_adx;
            r_steps      <= w_major_is_x ? w_adx : w_ady;
            r_x_inc      <= (i_end_x > i_start_x);
            r_x_dec      <= (i_end_x < i_start_x);
            r_y_inc      <= (i_end_y > i_start_y);
            r_y_dec      <= (i_end_y < i_start_y);
            r_addr       <= AB'(w_load_addr);
        end else if (i_cmd.step) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_err   <= n_err;
            r_steps <= r_steps - 1'b1;
            r_addr  <= n_addr;
        end
    end

    assign o_status.last   = (r_steps == '0);
    assign o_pixel_x       = r_x;
    assign o_pixel_y       = r_y;
    assign o_pixel_address = r_addr;

endmodule

`default_nettype wire

// ----- rtl/lnrast_ctrl.sv -----
`default_nettype none

module lnrast_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    input  wire                 i_m_tready,
    input  lnrast_pkg::t_status i_status,
    output lnrast_pkg::t_cmd    o_cmd
);

    lnrast_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lnrast_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        o_cmd      = '0;
        case (r_state)
            lnrast_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = lnrast_pkg::S_RUN;
                end
            end
            lnrast_pkg::S_RUN: begin
                o_m_tvalid = 1'b1;
                if (i_m_tready) begin
                    if (i_status.last) begin
                        // last beat leaves; take the next segment at once
                        o_s_tready = 1'b1;
                        if (i_s_tvalid) begin
                            o_cmd.load = 1'b1;
                        end else begin
                            n_state = lnrast_pkg::S_IDLE;
                        end
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            default: begin
                n_state = lnrast_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/line_rasterizer_core.sv -----
// First pixel: a segment's first pixel beat is offered in the cycle after its input beat.
// Throughput: one pixel per cycle while i_m_tready allows; a segment with major-axis
//   delta N emits N+1 pixels (at most 64 on a 6-bit canvas) and follows the previous
//   segment's last pixel without a gap when taken on that beat; from idle, a gap comes first.
// Reset: i_rst_n is synchronous, active low; it idles the controller, clears the
//   segment state and sets row_width to 64.
`default_nettype none

module line_rasterizer_core #(
    parameter int COORD_BITS = 6
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // configuration: row_width
    input  wire                                   i_cfg_wr_en,
    input  wire  [lnrast_pkg::ROW_WIDTH_BITS-1:0] i_cfg_wr_data,
    // segment input
    input  wire                                   i_s_tvalid,
    output logic                                  o_s_tready,
    // tdata, low to high: start_x, start_y, end_x, end_y, zero pad
    input  wire  [((4*COORD_BITS+7)/8)*8-1:0]     i_s_tdata,
    // pixel output
    output logic                                  o_m_tvalid,
    input  wire                                   i_m_tready,
    // tdata, low to high: pixel_x, pixel_y, pixel_address, zero pad
    output logic [((2*COORD_BITS+lnrast_pkg::ADDR_BITS+7)/8)*8-1:0] o_m_tdata,
    output logic                                  o_m_tlast
);

    localparam int OUT_W = ((2*COORD_BITS+lnrast_pkg::ADDR_BITS+7)/8)*8;

    lnrast_pkg::t_cmd    w_cmd;
    lnrast_pkg::t_status w_status;

    logic [COORD_BITS-1:0]            w_pixel_x;
    logic [COORD_BITS-1:0]            w_pixel_y;
    logic [lnrast_pkg::ADDR_BITS-1:0] w_pixel_address;

    // Controller: idle/run sequencing and both handshakes
    lnrast_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath: segment setup, the error-accumulator step, and the running
    // framebuffer address (multiplied once at setup, then stepped by +-1 and
    // +-row_width, all modulo 4096)
    lnrast_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_start_x       (i_s_tdata[COORD_BITS-1:0]),
        .i_start_y       (i_s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_end_x         (i_s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .i_end_y         (i_s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .o_pixel_x       (w_pixel_x),
        .o_pixel_y       (w_pixel_y),
        .o_pixel_address (w_pixel_address)
    );

    // The current pixel registers are the output stage: hold them while stalled
    assign o_m_tdata = OUT_W'({w_pixel_address, w_pixel_y, w_pixel_x});
    assign o_m_tlast = w_status.last;

    // A segment is taken only when no pixel is pending, or the last one leaves now
    a_in_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (!o_m_tvalid || (o_m_tlast && i_m_tready)))
        else $error("segment accepted while pixels still pending");

    // Every accepted segment produces a pixel beat on the next cycle
    a_first_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> o_m_tvalid)
        else $error("no pixel after segment accept");

    // No bubble inside a segment
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=> o_m_tvalid)
        else $error("pixel stream broke before the last pixel");

    // After the last pixel without a new segment, the block is free again
    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast && !i_s_tvalid) |=>
        (o_s_tready && !o_m_tvalid))
        else $error("controller did not return to idle");

endmodule

`default_nettype wire
